>>> src/tbc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Triangle barycentric coordinates: shared package
// Widths, register indexes, axis codes and the item type that the front part
// hands to the back part through the queue.
// ----------------------------------------------------------------------------
package tbc_pkg;

   localparam int FRAC_BITS_DEFAULT = 16;
   localparam int COORD_W           = 32;
   localparam int DIFF_W            = 33;
   localparam int PROD_W            = 66;
   localparam int SUM_W             = 67;
   localparam int MAG_W             = 66;
   localparam int AXIS_W            = 2;
   localparam int CSR_IDX_W         = 1;
   localparam int QUEUE_DEPTH       = 4;

   typedef enum logic [AXIS_W-1:0] {
      AXIS_X     = 2'd0,
      AXIS_Y     = 2'd1,
      AXIS_Z     = 2'd2,
      AXIS_Z_ALT = 2'd3
   } axis_code_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_AXIS_FIRST  = 1'b0,
      CSR_AXIS_SECOND = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [AXIS_W-1:0] first;
      logic [AXIS_W-1:0] second;
   } axis_sel_type;

   typedef struct packed {
      logic signed [SUM_W-1:0] det;
      logic signed [SUM_W-1:0] n1;
      logic signed [SUM_W-1:0] n2;
   } solve_item_type;

endpackage

>>> src/triangle_barycentric_coordinates.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Triangle barycentric coordinates: top level
// Barycentric weights of a 2D query point in a projected 3D triangle.
// ----------------------------------------------------------------------------
// Usage:
// An item on the req_ channel carries three vertices and a query point, all
// signed fixed point with FRAC_BITS fraction bits. It is accepted at a clock
// edge where req_valid is high and req_stall is low. Each item yields exactly
// one item on the rsp_ channel, taken when rsp_valid is high and rsp_stall low.
// The csr_ port writes the two projection axis registers. The user writes them
// only while the block idles; the block itself does not enforce it.
// Throughput is one item per cycle while no stall holds the flow: the front
// multipliers and every divider stage are pipelined, one quotient bit per
// stage, so the dividers set the latency but not the rate.
// Reset is synchronous and clears all valid state and restores the axes to
// x and y. When rsp_stall is high the result register holds, the back part
// freezes, the queue fills, and only then does req_stall rise.
// ----------------------------------------------------------------------------
module triangle_barycentric_coordinates import tbc_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_write_en,
   input  logic [CSR_IDX_W-1:0]      csr_index,
   input  logic [AXIS_W-1:0]         csr_wdata,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic signed [COORD_W-1:0] req_v0_x,
   input  logic signed [COORD_W-1:0] req_v0_y,
   input  logic signed [COORD_W-1:0] req_v0_z,
   input  logic signed [COORD_W-1:0] req_v1_x,
   input  logic signed [COORD_W-1:0] req_v1_y,
   input  logic signed [COORD_W-1:0] req_v1_z,
   input  logic signed [COORD_W-1:0] req_v2_x,
   input  logic signed [COORD_W-1:0] req_v2_y,
   input  logic signed [COORD_W-1:0] req_v2_z,
   input  logic signed [COORD_W-1:0] req_query_a,
   input  logic signed [COORD_W-1:0] req_query_b,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic signed [COORD_W-1:0] rsp_lambda_zero,
   output logic signed [COORD_W-1:0] rsp_lambda_one,
   output logic signed [COORD_W-1:0] rsp_lambda_two,
   output logic                      rsp_degenerate,
   output logic                      rsp_overflow
);

   axis_sel_type   axes_ff;
   logic           f_valid, f_stall, b_valid, b_stall;
   solve_item_type f_item, b_item;

   // Axis registers; code three selects z just as code two does.
   always_ff @(posedge clock) begin
      if (reset) begin
         axes_ff.first  <= AXIS_X;
         axes_ff.second <= AXIS_Y;
      end else if (csr_write_en) begin
         case (csr_index_type'(csr_index))
            CSR_AXIS_FIRST:  axes_ff.first  <= csr_wdata;
            CSR_AXIS_SECOND: axes_ff.second <= csr_wdata;
            default: ;
         endcase
      end
   end

   // The front part projects the triangle and forms the determinant and the
   // two numerators of Cramer's rule.
   tbc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .axes      (axes_ff),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .v0_x      (req_v0_x),
      .v0_y      (req_v0_y),
      .v0_z      (req_v0_z),
      .v1_x      (req_v1_x),
      .v1_y      (req_v1_y),
      .v1_z      (req_v1_z),
      .v2_x      (req_v2_x),
      .v2_y      (req_v2_y),
      .v2_z      (req_v2_z),
      .query_a   (req_query_a),
      .query_b   (req_query_b),
      .out_valid (f_valid),
      .out_item  (f_item),
      .out_stall (f_stall)
   );

   // The queue lets the front keep accepting while the back part is held.
   tbc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (f_valid),
      .in_stall  (f_stall),
      .in_item   (f_item),
      .out_valid (b_valid),
      .out_stall (b_stall),
      .out_item  (b_item)
   );

   // The back part divides, forms the third weight and saturates.
   tbc_back #(
      .FRAC_BITS (FRAC_BITS)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .in_valid        (b_valid),
      .in_stall        (b_stall),
      .in_item         (b_item),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_lambda_zero (rsp_lambda_zero),
      .rsp_lambda_one  (rsp_lambda_one),
      .rsp_lambda_two  (rsp_lambda_two),
      .rsp_degenerate  (rsp_degenerate),
      .rsp_overflow    (rsp_overflow)
   );

endmodule

>>> src/tbc_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Triangle barycentric coordinates: front part
// Projects the vertices, forms the edge vectors and the Cramer determinants.
// ----------------------------------------------------------------------------
module tbc_front import tbc_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  axis_sel_type              axes,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic signed [COORD_W-1:0] v0_x,
   input  logic signed [COORD_W-1:0] v0_y,
   input  logic signed [COORD_W-1:0] v0_z,
   input  logic signed [COORD_W-1:0] v1_x,
   input  logic signed [COORD_W-1:0] v1_y,
   input  logic signed [COORD_W-1:0] v1_z,
   input  logic signed [COORD_W-1:0] v2_x,
   input  logic signed [COORD_W-1:0] v2_y,
   input  logic signed [COORD_W-1:0] v2_z,
   input  logic signed [COORD_W-1:0] query_a,
   input  logic signed [COORD_W-1:0] query_b,
   output logic                      out_valid,
   output solve_item_type            out_item,
   input  logic                      out_stall
);

   function automatic logic signed [COORD_W-1:0] pick(
      input logic signed [COORD_W-1:0] x,
      input logic signed [COORD_W-1:0] y,
      input logic signed [COORD_W-1:0] z,
      input axis_code_type             code
   );
      case (code)
         AXIS_X:  pick = x;
         AXIS_Y:  pick = y;
         default: pick = z;
      endcase
   endfunction

   logic                     en;
   logic                     s1_v_ff, s2_v_ff, s3_v_ff;
   logic signed [COORD_W-1:0] a0, b0, a1, b1, a2, b2;
   logic signed [DIFF_W-1:0] da1_ff, db1_ff, da2_ff, db2_ff, dqa_ff, dqb_ff;
   logic signed [PROD_W-1:0] p0_ff, p1_ff, p2_ff, p3_ff, p4_ff, p5_ff;
   solve_item_type           item_ff;

   assign en        = !(s3_v_ff && out_stall);
   assign req_stall = !en;
   assign out_valid = s3_v_ff;
   assign out_item  = item_ff;

   always_comb begin
      a0 = pick(v0_x, v0_y, v0_z, axis_code_type'(axes.first));
      b0 = pick(v0_x, v0_y, v0_z, axis_code_type'(axes.second));
      a1 = pick(v1_x, v1_y, v1_z, axis_code_type'(axes.first));
      b1 = pick(v1_x, v1_y, v1_z, axis_code_type'(axes.second));
      a2 = pick(v2_x, v2_y, v2_z, axis_code_type'(axes.first));
      b2 = pick(v2_x, v2_y, v2_z, axis_code_type'(axes.second));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
         s3_v_ff <= 1'b0;
      end else if (en) begin
         s1_v_ff <= req_valid;
         s2_v_ff <= s1_v_ff;
         s3_v_ff <= s2_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         da1_ff <= DIFF_W'(a1) - DIFF_W'(a0);
         db1_ff <= DIFF_W'(b1) - DIFF_W'(b0);
         da2_ff <= DIFF_W'(a2) - DIFF_W'(a0);
         db2_ff <= DIFF_W'(b2) - DIFF_W'(b0);
         dqa_ff <= DIFF_W'(query_a) - DIFF_W'(a0);
         dqb_ff <= DIFF_W'(query_b) - DIFF_W'(b0);
         p0_ff  <= PROD_W'(da1_ff) * PROD_W'(db2_ff);
         p1_ff  <= PROD_W'(da2_ff) * PROD_W'(db1_ff);
         p2_ff  <= PROD_W'(dqa_ff) * PROD_W'(db2_ff);
         p3_ff  <= PROD_W'(da2_ff) * PROD_W'(dqb_ff);
         p4_ff  <= PROD_W'(da1_ff) * PROD_W'(dqb_ff);
         p5_ff  <= PROD_W'(dqa_ff) * PROD_W'(db1_ff);
         item_ff.det <= SUM_W'(p0_ff) - SUM_W'(p1_ff);
         item_ff.n1  <= SUM_W'(p2_ff) - SUM_W'(p3_ff);
         item_ff.n2  <= SUM_W'(p4_ff) - SUM_W'(p5_ff);
      end
   end

endmodule

>>> src/tbc_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Triangle barycentric coordinates: decoupling queue
// A short first-in first-out queue between the front and the back part.
// ----------------------------------------------------------------------------
module tbc_queue import tbc_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           in_valid,
   output logic           in_stall,
   input  solve_item_type in_item,
   output logic           out_valid,
   input  logic           out_stall,
   output solve_item_type out_item
);

   localparam int ADDR_W = $clog2(QUEUE_DEPTH);

   solve_item_type    mem [0:QUEUE_DEPTH-1];
   logic [ADDR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [ADDR_W:0]   count_ff;
   logic              push, pop;

   assign in_stall  = (count_ff == (ADDR_W+1)'(QUEUE_DEPTH));
   assign out_valid = (count_ff != '0);
   assign push      = in_valid && !in_stall;
   assign pop       = out_valid && !out_stall;
   assign out_item  = mem[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + ADDR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + ADDR_W'(1);
         end
         if (push && !pop) begin
            count_ff <= count_ff + (ADDR_W+1)'(1);
         end else if (pop && !push) begin
            count_ff <= count_ff - (ADDR_W+1)'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= in_item;
      end
   end

endmodule

>>> src/tbc_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Triangle barycentric coordinates: back part
// Two pipelined restoring dividers, one quotient bit per stage, then the
// third weight, saturation and the result register.
// ----------------------------------------------------------------------------
module tbc_back import tbc_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   output logic                      in_stall,
   input  solve_item_type            in_item,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic signed [COORD_W-1:0] rsp_lambda_zero,
   output logic signed [COORD_W-1:0] rsp_lambda_one,
   output logic signed [COORD_W-1:0] rsp_lambda_two,
   output logic                      rsp_degenerate,
   output logic                      rsp_overflow
);

   localparam int NW = MAG_W + FRAC_BITS;
   localparam int DW = MAG_W;
   localparam int QW = NW + 3;
   localparam logic signed [QW-1:0] ONE  = QW'(1) << FRAC_BITS;
   localparam logic signed [QW-1:0] LMAX = QW'(2147483647);
   localparam logic signed [QW-1:0] LMIN = ~LMAX;

   logic          en;
   logic          vld_ff   [0:NW];
   logic          neg1_ff  [0:NW];
   logic          neg2_ff  [0:NW];
   logic          degen_ff [0:NW];
   logic [NW-1:0] nq1_ff   [0:NW];
   logic [NW-1:0] nq2_ff   [0:NW];
   logic [DW-1:0] r1_ff    [0:NW];
   logic [DW-1:0] r2_ff    [0:NW];
   logic [DW-1:0] den_ff   [0:NW];
   logic [NW-1:0] nq1_in   [1:NW];
   logic [NW-1:0] nq2_in   [1:NW];
   logic [DW-1:0] r1_in    [1:NW];
   logic [DW-1:0] r2_in    [1:NW];

   logic [MAG_W-1:0]        mag_n1, mag_n2, mag_det;
   logic                    valid_ff, degen_out_ff, ovf_out_ff;
   logic signed [COORD_W-1:0] l0_ff, l1_ff, l2_ff;
   logic signed [QW-1:0]    sq0, sq1, sq2;
   logic signed [COORD_W-1:0] l0_in, l1_in, l2_in;
   logic                    ovf_in;

   assign en       = !valid_ff || !rsp_stall;
   assign in_stall = !en;

   assign mag_n1  = in_item.n1[SUM_W-1]  ? MAG_W'(-in_item.n1)  : MAG_W'(in_item.n1);
   assign mag_n2  = in_item.n2[SUM_W-1]  ? MAG_W'(-in_item.n2)  : MAG_W'(in_item.n2);
   assign mag_det = in_item.det[SUM_W-1] ? MAG_W'(-in_item.det) : MAG_W'(in_item.det);

   // One restoring step per stage: bring down the next dividend bit.
   always_comb begin
      logic [DW:0] t1, t2;
      for (int k = 1; k <= NW; k++) begin
         t1 = {r1_ff[k-1], nq1_ff[k-1][NW-1]};
         t2 = {r2_ff[k-1], nq2_ff[k-1][NW-1]};
         if (t1 >= {1'b0, den_ff[k-1]}) begin
            r1_in[k]  = DW'(t1 - {1'b0, den_ff[k-1]});
            nq1_in[k] = {nq1_ff[k-1][NW-2:0], 1'b1};
         end else begin
            r1_in[k]  = DW'(t1);
            nq1_in[k] = {nq1_ff[k-1][NW-2:0], 1'b0};
         end
         if (t2 >= {1'b0, den_ff[k-1]}) begin
            r2_in[k]  = DW'(t2 - {1'b0, den_ff[k-1]});
            nq2_in[k] = {nq2_ff[k-1][NW-2:0], 1'b1};
         end else begin
            r2_in[k]  = DW'(t2);
            nq2_in[k] = {nq2_ff[k-1][NW-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= NW; k++) begin
            vld_ff[k] <= 1'b0;
         end
      end else if (en) begin
         vld_ff[0] <= in_valid;
         for (int k = 1; k <= NW; k++) begin
            vld_ff[k] <= vld_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         nq1_ff[0]   <= NW'(mag_n1) << FRAC_BITS;
         nq2_ff[0]   <= NW'(mag_n2) << FRAC_BITS;
         r1_ff[0]    <= '0;
         r2_ff[0]    <= '0;
         den_ff[0]   <= mag_det;
         neg1_ff[0]  <= in_item.n1[SUM_W-1] ^ in_item.det[SUM_W-1];
         neg2_ff[0]  <= in_item.n2[SUM_W-1] ^ in_item.det[SUM_W-1];
         degen_ff[0] <= (in_item.det == '0);
         for (int k = 1; k <= NW; k++) begin
            nq1_ff[k]   <= nq1_in[k];
            nq2_ff[k]   <= nq2_in[k];
            r1_ff[k]    <= r1_in[k];
            r2_ff[k]    <= r2_in[k];
            den_ff[k]   <= den_ff[k-1];
            neg1_ff[k]  <= neg1_ff[k-1];
            neg2_ff[k]  <= neg2_ff[k-1];
            degen_ff[k] <= degen_ff[k-1];
         end
      end
   end

   always_comb begin
      sq1 = neg1_ff[NW] ? -QW'(nq1_ff[NW]) : QW'(nq1_ff[NW]);
      sq2 = neg2_ff[NW] ? -QW'(nq2_ff[NW]) : QW'(nq2_ff[NW]);
      sq0 = ONE - sq1 - sq2;
      ovf_in = 1'b0;
      if (sq0 > LMAX) begin
         l0_in = COORD_W'(LMAX);  ovf_in = 1'b1;
      end else if (sq0 < LMIN) begin
         l0_in = COORD_W'(LMIN);  ovf_in = 1'b1;
      end else begin
         l0_in = COORD_W'(sq0);
      end
      if (sq1 > LMAX) begin
         l1_in = COORD_W'(LMAX);  ovf_in = 1'b1;
      end else if (sq1 < LMIN) begin
         l1_in = COORD_W'(LMIN);  ovf_in = 1'b1;
      end else begin
         l1_in = COORD_W'(sq1);
      end
      if (sq2 > LMAX) begin
         l2_in = COORD_W'(LMAX);  ovf_in = 1'b1;
      end else if (sq2 < LMIN) begin
         l2_in = COORD_W'(LMIN);  ovf_in = 1'b1;
      end else begin
         l2_in = COORD_W'(sq2);
      end
      if (degen_ff[NW]) begin
         l0_in  = '0;
         l1_in  = '0;
         l2_in  = '0;
         ovf_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= vld_ff[NW];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         l0_ff        <= l0_in;
         l1_ff        <= l1_in;
         l2_ff        <= l2_in;
         degen_out_ff <= degen_ff[NW];
         ovf_out_ff   <= ovf_in;
      end
   end

   assign rsp_valid       = valid_ff;
   assign rsp_lambda_zero = l0_ff;
   assign rsp_lambda_one  = l1_ff;
   assign rsp_lambda_two  = l2_ff;
   assign rsp_degenerate  = degen_out_ff;
   assign rsp_overflow    = ovf_out_ff;

endmodule

>>> src/tbc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Triangle barycentric coordinates: port checker
// Watches the result channel of the top level over time.
// ----------------------------------------------------------------------------
module tbc_checker import tbc_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEFAULT
) (
   input logic                      clock,
   input logic                      reset,
   input logic                      rsp_valid,
   input logic                      rsp_stall,
   input logic signed [COORD_W-1:0] rsp_lambda_zero,
   input logic signed [COORD_W-1:0] rsp_lambda_one,
   input logic signed [COORD_W-1:0] rsp_lambda_two,
   input logic                      rsp_degenerate,
   input logic                      rsp_overflow
);

   localparam logic [COORD_W-1:0] ONE = COORD_W'(1) << FRAC_BITS;

   logic [COORD_W-1:0] weight_sum;
   assign weight_sum = COORD_W'(rsp_lambda_zero) + COORD_W'(rsp_lambda_one)
                       + COORD_W'(rsp_lambda_two);

   a_reset_clears: assert property (@(posedge clock)
      $past(reset) && !reset |-> !rsp_valid)
      else $error("result valid right after reset");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_lambda_zero)
         && $stable(rsp_degenerate))
      else $error("stalled result changed");

   a_degenerate_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_degenerate |-> rsp_lambda_zero == '0
         && rsp_lambda_one == '0 && rsp_lambda_two == '0 && !rsp_overflow)
      else $error("degenerate result carries weights");

   a_weights_sum: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_degenerate && !rsp_overflow |-> weight_sum == ONE)
      else $error("weights do not sum to one");

endmodule

bind triangle_barycentric_coordinates tbc_checker #(
   .FRAC_BITS (FRAC_BITS)
) u_tbc_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_lambda_zero (rsp_lambda_zero),
   .rsp_lambda_one  (rsp_lambda_one),
   .rsp_lambda_two  (rsp_lambda_two),
   .rsp_degenerate  (rsp_degenerate),
   .rsp_overflow    (rsp_overflow)
);

>>> sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Triangle barycentric coordinates: testbench
// A short table of directed triangles runs first. Random triangles follow
// under three idling patterns and several axis settings. Every accepted
// result is checked against the weights typed into its row or against a
// predictor that solves Cramer's rule exactly at full width.
// ----------------------------------------------------------------------------
module testbench;
   import tbc_pkg::*;

   localparam int FB       = FRAC_BITS_DEFAULT;
   localparam int LATENCY  = 100;
   localparam int RANDOM_N = 504;
   localparam int HOLD_N   = 120;

   // One triangle query: nine vertex coordinates and then the query point.
   typedef struct {
      logic signed [31:0] f [11];
   } query_type;

   typedef struct {
      logic signed [31:0] l0, l1, l2;
      logic               degen, ovf;
   } weights_type;

   // One row of the directed table. The expected weights are typed in only
   // where has_exp is set.
   typedef struct {
      logic [1:0]  ax_a, ax_b;
      query_type   q;
      bit          has_exp;
      weights_type w;
   } row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_write_en = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [AXIS_W-1:0] csr_wdata = '0;
   logic req_valid = 1'b0;
   logic req_stall;
   logic signed [31:0] req_f [11];
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [31:0] rsp_lambda_zero, rsp_lambda_one, rsp_lambda_two;
   logic rsp_degenerate, rsp_overflow;

   // The predictor keeps its own copy of the two axis registers.
   logic [1:0] axis_a_q = 2'd0;
   logic [1:0] axis_b_q = 2'd1;

   weights_type expected_weights [$];
   int errors = 0;
   int checked = 0;
   int degen_seen = 0;
   int ovf_seen = 0;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   bit hold_recv = 1'b0;

   initial begin
      for (int i = 0; i < 11; i++) req_f[i] = '0;
   end

   always #6 clock = ~clock;

   triangle_barycentric_coordinates u_dut (
      .clock           (clock),
      .reset           (reset),
      .csr_write_en    (csr_write_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_v0_x        (req_f[0]),
      .req_v0_y        (req_f[1]),
      .req_v0_z        (req_f[2]),
      .req_v1_x        (req_f[3]),
      .req_v1_y        (req_f[4]),
      .req_v1_z        (req_f[5]),
      .req_v2_x        (req_f[6]),
      .req_v2_y        (req_f[7]),
      .req_v2_z        (req_f[8]),
      .req_query_a     (req_f[9]),
      .req_query_b     (req_f[10]),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_lambda_zero (rsp_lambda_zero),
      .rsp_lambda_one  (rsp_lambda_one),
      .rsp_lambda_two  (rsp_lambda_two),
      .rsp_degenerate  (rsp_degenerate),
      .rsp_overflow    (rsp_overflow)
   );

   // Axis code three selects z, the same as code two.
   function automatic int axis_slot(logic [1:0] code);
      return (code == AXIS_Z_ALT) ? int'(AXIS_Z) : int'(code);
   endfunction

   function automatic logic signed [31:0] clamp32(logic signed [127:0] v, ref logic ovf);
      if (v > 128'sd2147483647) begin
         ovf = 1'b1;
         return 32'sh7FFF_FFFF;
      end
      if (v < -128'sd2147483648) begin
         ovf = 1'b1;
         return 32'sh8000_0000;
      end
      return v[31:0];
   endfunction

   // Barycentric weights by Cramer's rule, with exact 128-bit intermediates.
   // Division in SystemVerilog truncates toward zero, as the block does.
   function automatic weights_type solve_weights(query_type q);
      int fa, fb;
      logic signed [127:0] a0, b0, da1, db1, da2, db2, dqa, dqb, det, n1, n2;
      logic signed [127:0] q0, q1, q2;
      logic ovf;
      weights_type w;
      fa = axis_slot(axis_a_q);
      fb = axis_slot(axis_b_q);
      a0 = q.f[fa];
      b0 = q.f[fb];
      da1 = 128'(q.f[3 + fa]) - a0;
      db1 = 128'(q.f[3 + fb]) - b0;
      da2 = 128'(q.f[6 + fa]) - a0;
      db2 = 128'(q.f[6 + fb]) - b0;
      dqa = 128'(q.f[9]) - a0;
      dqb = 128'(q.f[10]) - b0;
      det = da1 * db2 - da2 * db1;
      w = '{default: '0};
      if (det == 0) begin
         w.degen = 1'b1;
         return w;
      end
      n1 = dqa * db2 - da2 * dqb;
      n2 = da1 * dqb - dqa * db1;
      q1 = (n1 <<< FB) / det;
      q2 = (n2 <<< FB) / det;
      q0 = (128'sd1 <<< FB) - q1 - q2;
      ovf = 1'b0;
      w.l0 = clamp32(q0, ovf);
      w.l1 = clamp32(q1, ovf);
      w.l2 = clamp32(q2, ovf);
      w.ovf = ovf;
      return w;
   endfunction

   task automatic report_mismatch(string what, logic signed [31:0] got, logic signed [31:0] exp);
      $display("MISMATCH result %0d %s: got %0d expected %0d", checked, what, got, exp);
      errors++;
   endtask

   task automatic write_axis(csr_index_type idx, logic [1:0] code);
      @(posedge clock);
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= code;
      @(posedge clock);
      csr_write_en <= 1'b0;
      if (idx == CSR_AXIS_FIRST) axis_a_q = code;
      else axis_b_q = code;
   endtask

   // Drops valid, waits until every expected result has come, then lets the
   // pipeline drain.
   task automatic drain;
      req_valid <= 1'b0;
      while (expected_weights.size() != 0) @(posedge clock);
      repeat (LATENCY) @(posedge clock);
   endtask

   task automatic set_axes(logic [1:0] a, logic [1:0] b);
      drain();
      write_axis(CSR_AXIS_FIRST, a);
      write_axis(CSR_AXIS_SECOND, b);
   endtask

   // Offers one item, after an optional random gap, and holds it until it
   // is taken. The expectation is queued at the accepting edge. Valid stays
   // high afterwards so that the next item can follow without a gap.
   task automatic send_query(query_type q, bit has_exp = 0, weights_type w = '{default: '0});
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      for (int i = 0; i < 11; i++) req_f[i] <= q.f[i];
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      expected_weights.push_back(has_exp ? w : solve_weights(q));
   endtask

   // Receiver: random stalls, plus a long hold when hold_recv is set.
   always @(posedge clock) begin
      if (reset) rsp_stall <= 1'b0;
      else rsp_stall <= hold_recv || ($urandom_range(99) < recv_idle_pct);
   end

   // Result checker: compares each accepted result with the oldest expectation.
   always @(posedge clock) begin
      weights_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_weights.size() == 0) begin
            $display("UNEXPECTED result with nothing pending");
            errors++;
         end else begin
            e = expected_weights.pop_front();
            if (rsp_lambda_zero !== e.l0) report_mismatch("lambda_zero", rsp_lambda_zero, e.l0);
            if (rsp_lambda_one !== e.l1) report_mismatch("lambda_one", rsp_lambda_one, e.l1);
            if (rsp_lambda_two !== e.l2) report_mismatch("lambda_two", rsp_lambda_two, e.l2);
            if (rsp_degenerate !== e.degen)
               report_mismatch("degenerate", rsp_degenerate, e.degen);
            if (rsp_overflow !== e.ovf) report_mismatch("overflow", rsp_overflow, e.ovf);
            if (e.degen) degen_seen++;
            if (e.ovf) ovf_seen++;
            checked++;
         end
      end
   end

   // Random coordinate: mostly small values, sometimes full range or extremes.
   function automatic logic signed [31:0] rand_coord();
      case ($urandom_range(9))
         0: return $urandom();
         1: return $urandom_range(1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
         2: return $signed($urandom_range(8)) - 4;
         default: return $signed($urandom_range(32'h0020_0000)) - 32'sh0010_0000;
      endcase
   endfunction

   function automatic query_type rand_query();
      query_type q;
      int fa, fb;
      for (int i = 0; i < 11; i++) q.f[i] = rand_coord();
      // Now and then collapse the triangle so that the determinant is zero.
      if ($urandom_range(19) == 0) begin
         fa = axis_slot(axis_a_q);
         fb = axis_slot(axis_b_q);
         q.f[6 + fa] = q.f[3 + fa];
         q.f[6 + fb] = q.f[3 + fb];
      end
      return q;
   endfunction

   function automatic query_type mk(int v0x, int v0y, int v0z, int v1x, int v1y, int v1z,
                                    int v2x, int v2y, int v2z, int qa, int qb);
      query_type q;
      q.f = '{v0x, v0y, v0z, v1x, v1y, v1z, v2x, v2y, v2z, qa, qb};
      return q;
   endfunction

   localparam int ONE = 1 << FB;
   localparam int MAXV = 32'sh7FFF_FFFF;
   localparam int MINV = 32'sh8000_0000;

   row_type directed [$];

   initial begin
      weights_type zero_w, degen_w;
      zero_w = '{default: '0};
      degen_w = '{default: '0};
      degen_w.degen = 1'b1;

      // Unit right triangle in the x-y plane: the vertices give unit weights.
      directed.push_back('{2'd0, 2'd1, mk(0, 0, 0, ONE, 0, 0, 0, ONE, 0, 0, 0),
                           1, '{ONE, 0, 0, 0, 0}});
      directed.push_back('{2'd0, 2'd1, mk(0, 0, 0, ONE, 0, 0, 0, ONE, 0, ONE, 0),
                           1, '{0, ONE, 0, 0, 0}});
      directed.push_back('{2'd0, 2'd1, mk(0, 0, 0, ONE, 0, 0, 0, ONE, 0, 0, ONE),
                           1, '{0, 0, ONE, 0, 0}});
      // All vertices equal: zero determinant.
      directed.push_back('{2'd0, 2'd1, mk(5, 5, 5, 5, 5, 5, 5, 5, 5, MAXV, MINV),
                           1, degen_w});
      // Same axis twice gives a degenerate result whatever the data.
      directed.push_back('{2'd2, 2'd2, mk(0, 0, 0, ONE, 3, 7, 9, ONE, -4, 1, 2),
                           1, degen_w});
      directed.push_back('{2'd3, 2'd2, mk(1, 2, 3, 4, 5, 6, 7, 8, 10, 11, 12),
                           1, degen_w});
      // Axis code three acts as z, paired with x and with y.
      directed.push_back('{2'd3, 2'd0, mk(0, 0, 0, 0, 9, ONE, ONE, 9, 0, 0, 0),
                           1, '{ONE, 0, 0, 0, 0}});
      directed.push_back('{2'd1, 2'd3, mk(0, 0, 0, 0, ONE, 0, 0, 0, ONE, ONE, ONE),
                           0, zero_w});
      // Tiny triangle with a far query point: the weights saturate.
      directed.push_back('{2'd0, 2'd1, mk(0, 0, 0, 1, 0, 0, 0, 1, 0, MAXV, MAXV),
                           1, '{MINV, MAXV, MAXV, 0, 1}});
      directed.push_back('{2'd0, 2'd1, mk(0, 0, 0, 1, 0, 0, 0, 1, 0, MINV, MINV),
                           0, zero_w});
      // Extreme coordinates everywhere.
      directed.push_back('{2'd0, 2'd1, mk(MINV, MINV, MINV, MAXV, MINV, 0, MINV, MAXV, 0,
                                          MAXV, MAXV), 0, zero_w});
      directed.push_back('{2'd0, 2'd2, mk(MAXV, 0, MAXV, MINV, 0, MAXV, MAXV, 0, MINV,
                                          MINV, MINV), 0, zero_w});
      directed.push_back('{2'd2, 2'd1, mk(-1, -1, -1, MAXV, MINV, MAXV, MINV, MAXV, -1,
                                          0, -1), 0, zero_w});
      directed.push_back('{2'd1, 2'd0, mk(3, -7, 0, -ONE, 2 * ONE, 0, 5 * ONE, -3, 0,
                                          ONE, ONE), 0, zero_w});
      directed.push_back('{2'd1, 2'd0, mk(0, 0, 0, 7, 0, 0, 0, 3, 0, 1, 1), 0, zero_w});

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed table. The axes are rewritten only when a row changes them.
      foreach (directed[i]) begin
         if (directed[i].ax_a != axis_a_q || directed[i].ax_b != axis_b_q)
            set_axes(directed[i].ax_a, directed[i].ax_b);
         send_query(directed[i].q, directed[i].has_exp, directed[i].w);
      end

      // Random part in three idling phases, each under three random axis settings.
      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 21 : (phase == 1) ? 62 : 0;
         recv_idle_pct = (phase == 0) ? 62 : (phase == 1) ? 21 : 0;
         for (int s = 0; s < 3; s++) begin
            set_axes($urandom_range(3), $urandom_range(3));
            for (int n = 0; n < RANDOM_N / 9; n++) send_query(rand_query());
         end
      end

      // The receiver holds off for a long stretch while items keep coming,
      // more than the whole pipeline holds, so req_stall must rise.
      set_axes(2'd0, 2'd1);
      fork
         begin
            hold_recv = 1'b1;
            repeat (300) @(posedge clock);
            hold_recv = 1'b0;
         end
         begin
            for (int n = 0; n < HOLD_N; n++) send_query(rand_query());
            req_valid <= 1'b0;
         end
      join

      // The sender pauses until everything is back, then sends a final burst.
      while (expected_weights.size() != 0) @(posedge clock);
      for (int n = 0; n < 10; n++) send_query(rand_query());

      drain();
      $display("Checked %0d results, %0d degenerate and %0d saturated,", checked,
               degen_seen, ovf_seen);
      $display("under random axis settings, three idling patterns and a long hold.");
      if (errors == 0) $display("All tests passed");
      else $display("Some tests failed");
      $finish;
   end

   initial begin
      #20ms;
      $display("Some tests failed");
      $finish;
   end

endmodule
